>>> design/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// i2cram_pkg: shared types for the I2C register access master
// Bus phase and byte stage codes, configuration indices and reset values, and the per-phase length in ticks.
// ----------------------------------------------------------------------------
package i2cram_pkg;

	typedef enum logic [3:0] {
		P_IDLE     = 4'd0,
		P_ST_HI    = 4'd1,
		P_ST_LO    = 4'd2,
		P_TX_SET   = 4'd3,
		P_TX_HIGH  = 4'd4,
		P_TX_LOW   = 4'd5,
		P_ACK_REL  = 4'd6,
		P_ACK_HI   = 4'd7,
		P_ACK_POLL = 4'd8,
		P_RX_LOW   = 4'd9,
		P_RX_HIGH  = 4'd10,
		P_RA_LOW   = 4'd11,
		P_RA_HIGH  = 4'd12,
		P_SP_LO    = 4'd13,
		P_SP_HI    = 4'd14
	} phase_t;

	// which byte is on the bus
	typedef enum logic [1:0] {
		S_DEV_W = 2'd0,
		S_REG   = 2'd1,
		S_DEV_R = 2'd2,
		S_DATA  = 2'd3
	} stage_t;

	typedef enum logic [1:0] {
		CFG_DEV_ADDR  = 2'd0,
		CFG_POLL_LIM  = 2'd1,
		CFG_TICKS     = 2'd2
	} cfg_idx_t;

	localparam logic [6:0] DEV_ADDR_RST  = 7'd56;
	localparam logic [7:0] POLL_LIM_RST  = 8'd250;
	localparam logic [7:0] TICKS_RST     = 8'd1;

	// phase length in ticks: unit count times ticks per unit (at most 4 * 255)
	function automatic logic [9:0] phase_ticks(phase_t p, logic [7:0] tpu);
		logic [9:0] t;
		t = {2'b00, tpu};
		case (p)
			P_ST_HI, P_ST_LO, P_SP_LO, P_SP_HI:            phase_ticks = t << 2;
			P_TX_SET, P_TX_HIGH, P_TX_LOW, P_RX_LOW,
			P_RA_LOW, P_RA_HIGH:                           phase_ticks = t << 1;
			P_ACK_REL, P_ACK_HI, P_RX_HIGH:                phase_ticks = t;
			default:                                       phase_ticks = 10'd0;
		endcase
	endfunction

endpackage

>>> design/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// i2c_register_access_master: tick-driven I2C register read/write master
// Generates SCL/SDA for a register write or register read, one word per tick.
// ----------------------------------------------------------------------------
// Usage
//  Input channel (in_valid/in_ready): one word is one bus timing tick, holding
//  the sampled SDA level, the next write byte and, when idle, a request
//  (start_req, func, reg_addr, length).
//  Output channel (out_valid/out_ready): one word per input word, with the
//  SCL/SDA drive for that tick and the status flags (busy, write_taken,
//  read_valid/read_byte, done/fail).
//  The result of a word is held in the output register.
//  Throughput: one word per cycle while the output is not stalled; the whole
//  step runs in one pass between the bus state registers and the output register.
//  Stall: in_ready follows the output register, so the block takes a new
//  word whenever the held result is taken in the same cycle or none is held.
//  Reset: the bus returns to idle and no result is held; configuration
//  returns to address 0x38, poll limit 250, one tick per unit.
//  Configuration (cfg_we/cfg_index/cfg_data) may only be written when idle.
// ----------------------------------------------------------------------------
module i2c_register_access_master
	import i2cram_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	// input words
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       start_req,
	input  logic       func,
	input  logic [7:0] reg_addr,
	input  logic [7:0] length,
	input  logic [7:0] wr_data,
	input  logic       sda_in,
	// result words
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_out,
	output logic       sda_out,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       write_taken,
	output logic       read_valid,
	output logic [7:0] read_byte,
	output logic       done_res,
	output logic       fail
);

	// configuration
	logic [6:0] dev_addr_q;
	logic [7:0] poll_lim_q;
	logic [7:0] ticks_q;

	// bus state
	phase_t     phase_q,  n_phase;
	stage_t     stage_q,  n_stage;
	logic [9:0] delay_q,  n_delay;
	logic [2:0] bit_q,    n_bit;
	logic [7:0] shift_q,  n_shift;
	logic [7:0] bytes_q,  n_bytes;
	logic [7:0] reg_q,    n_reg;
	logic       kind_q,   n_kind;
	logic [7:0] poll_q,   n_poll;
	logic       fail_q,   n_fail;

	// result register
	logic       out_valid_q;
	logic       scl_q, sda_q, drv_q, busy_q, wtk_q, rdv_q, done_q, fail_out_q;
	logic [7:0] rbyte_q;

	// combinational step
	logic       c_scl, c_sda, c_drv, c_busy;
	logic       tk_write, tk_valid, tk_done, do_enter;
	logic [7:0] tpu;
	logic       accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign tpu      = (ticks_q == 8'd0) ? 8'd1 : ticks_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			poll_lim_q <= POLL_LIM_RST;
			ticks_q    <= TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEV_ADDR: dev_addr_q <= cfg_data[6:0];
				CFG_POLL_LIM: poll_lim_q <= cfg_data;
				CFG_TICKS:    ticks_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	// ---------------------------------------------------- line drive per phase
	always_comb begin
		c_scl  = 1'b1;
		c_sda  = 1'b1;
		c_drv  = 1'b1;
		c_busy = 1'b1;
		unique case (phase_q)
			P_IDLE:               c_busy = 1'b0;
			P_ST_LO:              c_sda = 1'b0;
			P_TX_SET, P_TX_LOW: begin
				c_scl = 1'b0;
				c_sda = shift_q[7];
			end
			P_TX_HIGH:            c_sda = shift_q[7];
			P_ACK_REL, P_RX_LOW: begin
				c_scl = 1'b0;
				c_drv = 1'b0;
			end
			P_ACK_HI, P_ACK_POLL, P_RX_HIGH: c_drv = 1'b0;
			// acknowledge low, except the last read byte is not acknowledged
			P_RA_LOW: begin
				c_scl = 1'b0;
				c_sda = (bytes_q == 8'd0);
			end
			P_RA_HIGH:            c_sda = (bytes_q == 8'd0);
			P_SP_LO: begin
				c_scl = 1'b0;
				c_sda = 1'b0;
			end
			P_ST_HI, P_SP_HI:     ;
			default:              c_busy = 1'b0;
		endcase
	end

	// ------------------------------------------------------- next bus state
	always_comb begin
		n_phase  = phase_q;
		n_stage  = stage_q;
		n_delay  = delay_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_bytes  = bytes_q;
		n_reg    = reg_q;
		n_kind   = kind_q;
		n_poll   = poll_q;
		n_fail   = fail_q;
		tk_write = 1'b0;
		tk_valid = 1'b0;
		tk_done  = 1'b0;
		do_enter = 1'b0;

		unique case (phase_q)
			P_IDLE: begin
				if (start_req) begin
					n_reg    = reg_addr;
					n_kind   = func;
					n_bytes  = length;
					n_fail   = 1'b0;
					n_stage  = S_DEV_W;
					n_shift  = {dev_addr_q, 1'b0};
					n_phase  = P_ST_HI;
					do_enter = 1'b1;
				end
			end
			P_ACK_POLL: begin
				if (!sda_in || (poll_q >= poll_lim_q)) begin
					do_enter = 1'b1;
					unique case (stage_q)
						// header acknowledge failures are ignored
						S_DEV_W: begin
							n_stage = S_REG;
							n_shift = reg_q;
							n_bit   = 3'd0;
							n_phase = P_TX_SET;
						end
						S_REG: begin
							if (kind_q) begin
								n_stage = S_DEV_R;
								n_shift = {dev_addr_q, 1'b1};
								n_phase = P_ST_HI;
							end else if (bytes_q == 8'd0) begin
								n_phase = P_SP_LO;
							end else begin
								tk_write = 1'b1;
								n_bytes  = bytes_q - 8'd1;
								n_stage  = S_DATA;
								n_shift  = wr_data;
								n_bit    = 3'd0;
								n_phase  = P_TX_SET;
							end
						end
						S_DEV_R: begin
							if (bytes_q == 8'd0) begin
								n_phase = P_SP_LO;
							end else begin
								n_bit   = 3'd0;
								n_shift = 8'd0;
								n_phase = P_RX_LOW;
							end
						end
						default: begin
							if (sda_in) begin
								// data byte not acknowledged: stop and flag
								n_fail  = 1'b1;
								n_phase = P_SP_LO;
							end else if (bytes_q == 8'd0) begin
								n_phase = P_SP_LO;
							end else begin
								tk_write = 1'b1;
								n_bytes  = bytes_q - 8'd1;
								n_shift  = wr_data;
								n_bit    = 3'd0;
								n_phase  = P_TX_SET;
							end
						end
					endcase
				end else begin
					n_poll = poll_q + 8'd1;
				end
			end
			P_ST_HI, P_ST_LO, P_TX_SET, P_TX_HIGH, P_TX_LOW, P_ACK_REL, P_ACK_HI,
			P_RX_LOW, P_RX_HIGH, P_RA_LOW, P_RA_HIGH, P_SP_LO, P_SP_HI: begin
				// sample on the first high tick of a received bit
				if (phase_q == P_RX_HIGH && delay_q == {2'b00, tpu})
					n_shift = {shift_q[6:0], sda_in};
				if (delay_q > 10'd1) begin
					n_delay = delay_q - 10'd1;
				end else begin
					do_enter = 1'b1;
					unique case (phase_q)
						P_ST_HI:   n_phase = P_ST_LO;
						P_ST_LO: begin
							n_bit   = 3'd0;
							n_phase = P_TX_SET;
						end
						P_TX_SET:  n_phase = P_TX_HIGH;
						P_TX_HIGH: n_phase = P_TX_LOW;
						P_TX_LOW: begin
							n_shift = {shift_q[6:0], 1'b0};
							if (bit_q == 3'd7) begin
								n_phase = P_ACK_REL;
							end else begin
								n_bit   = bit_q + 3'd1;
								n_phase = P_TX_SET;
							end
						end
						P_ACK_REL: n_phase = P_ACK_HI;
						P_ACK_HI: begin
							n_poll  = 8'd0;
							n_phase = P_ACK_POLL;
						end
						P_RX_LOW:  n_phase = P_RX_HIGH;
						P_RX_HIGH: begin
							if (bit_q == 3'd7) begin
								tk_valid = 1'b1;
								n_bytes  = bytes_q - 8'd1;
								n_phase  = P_RA_LOW;
							end else begin
								n_bit   = bit_q + 3'd1;
								n_phase = P_RX_LOW;
							end
						end
						P_RA_LOW:  n_phase = P_RA_HIGH;
						P_RA_HIGH: begin
							if (bytes_q == 8'd0) begin
								n_phase = P_SP_LO;
							end else begin
								n_bit   = 3'd0;
								n_shift = 8'd0;
								n_phase = P_RX_LOW;
							end
						end
						P_SP_LO:   n_phase = P_SP_HI;
						default: begin
							tk_done = 1'b1;
							n_phase = P_IDLE;
						end
					endcase
				end
			end
			default: n_phase = P_IDLE;
		endcase

		if (do_enter)
			n_delay = phase_ticks(n_phase, tpu);
	end

	// ----------------------------------------------------------- bus state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			stage_q <= S_DEV_W;
			delay_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			bytes_q <= '0;
			reg_q   <= '0;
			kind_q  <= 1'b0;
			poll_q  <= '0;
			fail_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= n_phase;
			stage_q <= n_stage;
			delay_q <= n_delay;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			bytes_q <= n_bytes;
			reg_q   <= n_reg;
			kind_q  <= n_kind;
			poll_q  <= n_poll;
			fail_q  <= n_fail;
		end
	end

	// ------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scl_q      <= c_scl;
			sda_q      <= c_sda;
			drv_q      <= c_drv;
			busy_q     <= c_busy;
			wtk_q      <= tk_write;
			rdv_q      <= tk_valid;
			rbyte_q    <= tk_valid ? n_shift : 8'd0;
			done_q     <= tk_done;
			fail_out_q <= tk_done & fail_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign scl_out     = scl_q;
	assign sda_out     = sda_q;
	assign sda_drive   = drv_q;
	assign busy_res    = busy_q;
	assign write_taken = wtk_q;
	assign read_valid  = rdv_q;
	assign read_byte   = rbyte_q;
	assign done_res    = done_q;
	assign fail        = fail_out_q;

`ifndef ASSERT_OFF
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted word produced no result");

	a_fail_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fail |-> done_res)
		else $error("fail raised outside the done tick");

	// the next byte is taken on the acknowledge poll: SCL high, SDA released
	a_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_taken |-> busy_res && !sda_drive && scl_out)
		else $error("write byte taken outside an active transfer");

	a_read_while_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> !sda_drive && busy_res)
		else $error("read byte completed while SDA driven");

	a_idle_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_IDLE |-> delay_q == 10'd0 || $past(accept))
		else $error("idle with a pending delay count");
`endif

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for i2c_register_access_master
// Drives one bus tick per input word and checks every result word against a
// cycle-true predictor of the SCL/SDA sequencer. A short table of register
// transactions covers the edges. A random transaction follows, on random
// settings. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import i2cram_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int POLL_FOREVER = 1 << 20;
	localparam int MAX_REPORTS = 40;
	localparam logic FN_WRITE = 1'b0;
	localparam logic FN_READ = 1'b1;

	// how the bench answers each acknowledge poll of a transaction
	typedef enum logic [2:0] {
		ACK_NOW,       // SDA low on the first poll
		ACK_SLOW,      // up to three high polls, then low
		ACK_AT_LIMIT,  // exactly poll_limit high polls, then low: last chance
		NACK_HDR,      // header bytes time out, data bytes ack at once
		NACK_DATA,     // one chosen data byte times out
		ACK_MIXED      // anything, timeouts included
	} ack_plan_t;

	typedef enum logic [1:0] {CHK_NONE, CHK_OK, CHK_FAIL} done_chk_t;

	typedef struct packed {
		logic [6:0] addr;
		logic [7:0] limit;
		logic [7:0] tpu;
		logic       fn;
		logic [7:0] reg_a;
		logic [7:0] len;
		ack_plan_t  plan;
		logic [7:0] nack_at;
		done_chk_t  chk;
	} txn_row_t;

	// one result word
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       busy;
		logic       wtaken;
		logic       rvalid;
		logic [7:0] rbyte;
		logic       done;
		logic       fail;
	} pins_t;

	// Directed transactions. Config columns are written first (when they differ).
	// The last column is the done/fail outcome, typed in where it is obvious.
	localparam int N_ROWS = 3;
	localparam txn_row_t ROWS [N_ROWS] = '{
		'{7'd56,  8'd250, 8'd1,   FN_WRITE, 8'h5A, 8'd0,   ACK_NOW,      8'd0, CHK_OK},
		'{7'd127, 8'd1,   8'd0,   FN_READ,  8'hFF, 8'd2,   NACK_HDR,     8'd0, CHK_OK},
		'{7'd0,   8'd1,   8'd1,   FN_WRITE, 8'h10, 8'd1,   NACK_DATA,    8'd0, CHK_FAIL}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       start_req;
	logic       func;
	logic [7:0] reg_addr;
	logic [7:0] length;
	logic [7:0] wr_data;
	logic       sda_in;
	logic       out_valid;
	logic       out_ready;
	logic       scl_out;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       write_taken;
	logic       read_valid;
	logic [7:0] read_byte;
	logic       done_res;
	logic       fail;

	i2c_register_access_master dut (.*);

	// ---- predictor state: a bus-level copy of the sequencer ----
	phase_t     bus_phase;
	stage_t     bus_stage;
	logic [9:0] unit_left;   // ticks left in the current phase
	logic [2:0] bit_no;
	logic [7:0] shreg;       // byte going out, or byte being assembled
	logic [7:0] bytes_left;
	logic [7:0] held_reg;
	logic       held_kind;
	logic [7:0] polls;
	logic       fail_seen;
	logic [6:0] dev_addr;
	logic [7:0] poll_limit;
	logic [7:0] tick_div;
	// per-tick strobes
	logic       took_wr;
	logic       byte_out;
	logic       finished;
	logic [7:0] next_wr;

	pins_t pins_due[$];      // result words still owed by the block
	int    errors;
	int    done_seen;        // done words seen on the output
	logic  last_fail;        // fail flag of the latest done word
	int    rx_hold;          // long receiver hold-off, picked up by the receiver
	bit    no_idle;          // both sides run flat out while set
	int    cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- predictor ----
	function logic [7:0] tick_unit();
		// a divider of zero behaves as one
		return (tick_div == 8'd0) ? 8'd1 : tick_div;
	endfunction

	function int units_of(phase_t p);
		case (p)
			P_ST_HI, P_ST_LO, P_SP_LO, P_SP_HI:       return 4;
			P_TX_SET, P_TX_HIGH, P_TX_LOW, P_RX_LOW,
			P_RA_LOW, P_RA_HIGH:                      return 2;
			P_ACK_REL, P_ACK_HI, P_RX_HIGH:           return 1;
			default:                                  return 0;
		endcase
	endfunction

	function void go_phase(phase_t p);
		bus_phase = p;
		unit_left = 10'(units_of(p) * int'(tick_unit()));
	endfunction

	function void load_byte(logic [7:0] b);
		shreg = b;
		bit_no = 3'd0;
		go_phase(P_TX_SET);
	endfunction

	function void next_data_byte();
		if (bytes_left == 8'd0) begin
			go_phase(P_SP_LO);
		end else begin
			took_wr = 1'b1;
			bytes_left = bytes_left - 8'd1;
			bus_stage = S_DATA;
			load_byte(next_wr);
		end
	endfunction

	function void begin_rx_byte();
		bit_no = 3'd0;
		shreg = 8'd0;
		go_phase(P_RX_LOW);
	endfunction

	// a header timeout is shrugged off; only a data byte can fail
	function void settle_ack(logic ok);
		case (bus_stage)
			S_DEV_W: begin
				bus_stage = S_REG;
				load_byte(held_reg);
			end
			S_REG: begin
				if (held_kind == FN_WRITE) begin
					next_data_byte();
				end else begin
					// repeated start, then the read address
					bus_stage = S_DEV_R;
					shreg = {dev_addr, 1'b1};
					go_phase(P_ST_HI);
				end
			end
			S_DEV_R: begin
				if (bytes_left == 8'd0) go_phase(P_SP_LO);
				else begin_rx_byte();
			end
			default: begin
				if (!ok) begin
					fail_seen = 1'b1;
					go_phase(P_SP_LO);
				end else begin
					next_data_byte();
				end
			end
		endcase
	endfunction

	function void segment_over();
		case (bus_phase)
			P_ST_HI:   go_phase(P_ST_LO);
			P_ST_LO:   load_byte(shreg);
			P_TX_SET:  go_phase(P_TX_HIGH);
			P_TX_HIGH: go_phase(P_TX_LOW);
			P_TX_LOW: begin
				shreg = {shreg[6:0], 1'b0};
				if (bit_no == 3'd7) begin
					go_phase(P_ACK_REL);
				end else begin
					bit_no = bit_no + 3'd1;
					go_phase(P_TX_SET);
				end
			end
			P_ACK_REL: go_phase(P_ACK_HI);
			P_ACK_HI: begin
				polls = 8'd0;
				go_phase(P_ACK_POLL);
			end
			P_RX_LOW:  go_phase(P_RX_HIGH);
			P_RX_HIGH: begin
				if (bit_no == 3'd7) begin
					byte_out = 1'b1;
					bytes_left = bytes_left - 8'd1;
					go_phase(P_RA_LOW);
				end else begin
					bit_no = bit_no + 3'd1;
					go_phase(P_RX_LOW);
				end
			end
			P_RA_LOW:  go_phase(P_RA_HIGH);
			P_RA_HIGH: begin
				if (bytes_left == 8'd0) go_phase(P_SP_LO);
				else begin_rx_byte();
			end
			P_SP_LO:   go_phase(P_SP_HI);
			default: begin
				finished = 1'b1;
				go_phase(P_IDLE);
			end
		endcase
	endfunction

	function void clear_model();
		dev_addr = DEV_ADDR_RST;
		poll_limit = POLL_LIM_RST;
		tick_div = TICKS_RST;
		bus_phase = P_IDLE;
		bus_stage = S_DEV_W;
		unit_left = '0;
		bit_no = '0;
		shreg = '0;
		bytes_left = '0;
		held_reg = '0;
		held_kind = 1'b0;
		polls = '0;
		fail_seen = 1'b0;
	endfunction

	// one tick: pin levels come from the state at the start of the tick
	function pins_t bus_tick(logic st, logic fn, logic [7:0] ra, logic [7:0] len,
			logic [7:0] wd, logic sda);
		pins_t p;
		logic  out_bit;
		logic  ack_lvl;
		logic  fail_was;
		out_bit = shreg[7];
		ack_lvl = (bytes_left == 8'd0);  // NACK on the last read byte
		fail_was = fail_seen;
		took_wr = 1'b0;
		byte_out = 1'b0;
		finished = 1'b0;
		next_wr = wd;
		p = '0;
		p.scl = 1'b1;
		p.sda = 1'b1;
		p.drv = 1'b1;
		p.busy = (bus_phase != P_IDLE);
		case (bus_phase)
			P_ST_LO: p.sda = 1'b0;
			P_TX_SET, P_TX_LOW: begin
				p.scl = 1'b0;
				p.sda = out_bit;
			end
			P_TX_HIGH: p.sda = out_bit;
			P_ACK_REL, P_RX_LOW: begin
				p.scl = 1'b0;
				p.drv = 1'b0;
			end
			P_ACK_HI, P_ACK_POLL, P_RX_HIGH: p.drv = 1'b0;
			P_RA_LOW: begin
				p.scl = 1'b0;
				p.sda = ack_lvl;
			end
			P_RA_HIGH: p.sda = ack_lvl;
			P_SP_LO: begin
				p.scl = 1'b0;
				p.sda = 1'b0;
			end
			default: ;
		endcase

		if (bus_phase == P_IDLE) begin
			if (st) begin
				held_reg = ra;
				held_kind = fn;
				bytes_left = len;
				fail_seen = 1'b0;
				bus_stage = S_DEV_W;
				shreg = {dev_addr, 1'b0};
				go_phase(P_ST_HI);
			end
		end else if (bus_phase == P_ACK_POLL) begin
			if (!sda) settle_ack(1'b1);
			else if (polls >= poll_limit) settle_ack(1'b0);
			else polls = polls + 8'd1;
		end else begin
			// read bits are taken on the first high tick
			if (bus_phase == P_RX_HIGH && unit_left == {2'b00, tick_unit()})
				shreg = {shreg[6:0], sda};
			if (unit_left > 10'd1) unit_left = unit_left - 10'd1;
			else segment_over();
		end

		p.wtaken = took_wr;
		p.rvalid = byte_out;
		p.rbyte = byte_out ? shreg : 8'd0;
		p.done = finished;
		p.fail = finished ? fail_was : 1'b0;
		return p;
	endfunction

	// ---- stimulus helpers ----
	// mostly back to back, some short gaps, the odd long one
	function int idle_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// entered and left at a falling edge
	task send_word(input logic st, input logic fn, input logic [7:0] ra,
			input logic [7:0] len, input logic [7:0] wd, input logic sda);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start_req = st;
		func = fn;
		reg_addr = ra;
		length = len;
		wr_data = wd;
		sda_in = sda;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pins_due.push_back(bus_tick(st, fn, ra, len, wd, sda));
		@(negedge clk);
	endtask

	task wait_quiet();
		in_valid = 1'b0;
		while (pins_due.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task set_reg(input cfg_idx_t idx, input logic [7:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_DEV_ADDR: dev_addr = val[6:0];
			CFG_POLL_LIM: poll_limit = val;
			CFG_TICKS:    tick_div = val;
			default: ;
		endcase
	endtask

	// registers only change with the bus idle and nothing in flight
	task apply_cfg(input logic [6:0] addr, input logic [7:0] limit, input logic [7:0] tpu);
		if (addr != dev_addr || limit != poll_limit || tpu != tick_div) begin
			wait_quiet();
			if (addr != dev_addr) set_reg(CFG_DEV_ADDR, {1'b0, addr});
			if (limit != poll_limit) set_reg(CFG_POLL_LIM, limit);
			if (tpu != tick_div) set_reg(CFG_TICKS, tpu);
		end
	endtask

	// high polls to give before pulling SDA low at the current ack
	function int high_polls(ack_plan_t plan, int data_idx, int nack_at);
		bit hdr;
		int r;
		hdr = (bus_stage != S_DATA);
		case (plan)
			ACK_NOW:      return 0;
			ACK_SLOW:     return $urandom_range(0, 3);
			ACK_AT_LIMIT: return int'(poll_limit);
			NACK_HDR:     return hdr ? POLL_FOREVER : 0;
			NACK_DATA:    return (!hdr && data_idx == nack_at) ? POLL_FOREVER : 0;
			default: begin
				r = $urandom_range(0, 99);
				if (r < 70) return 0;
				if (r < 80) return $urandom_range(1, 2);
				if (r < 88) return int'(poll_limit);
				if (r < 95) return int'(poll_limit) + 1;
				return POLL_FOREVER;
			end
		endcase
	endfunction

	// One full transaction: the request word, then ticks until the bus is idle
	// again. Requests keep arriving while busy and must be ignored.
	task run_txn(input logic fn, input logic [7:0] ra, input logic [7:0] len,
			input ack_plan_t plan, input int nack_at);
		int   high_left;
		int   data_acks;
		bit   polling;
		logic sda;
		high_left = 0;
		data_acks = 0;
		polling = 1'b0;
		send_word(1'b1, fn, ra, len, 8'($urandom), 1'($urandom));
		while (bus_phase != P_IDLE) begin
			if (bus_phase == P_ACK_POLL) begin
				if (!polling) begin
					polling = 1'b1;
					high_left = high_polls(plan, data_acks, nack_at);
					if (bus_stage == S_DATA) data_acks++;
				end
				sda = (high_left > 0);
				if (high_left > 0) high_left--;
			end else begin
				polling = 1'b0;
				sda = 1'($urandom);  // read data, or noise the block ignores
			end
			send_word(($urandom_range(0, 3) == 0), 1'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), sda);
		end
	endtask

	function ack_plan_t pick_plan();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return ACK_MIXED;
		if (r < 65) return ACK_NOW;
		if (r < 75) return ACK_SLOW;
		if (r < 85) return NACK_HDR;
		if (r < 95) return NACK_DATA;
		return ACK_AT_LIMIT;
	endfunction

	task flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
	endtask

	// ---- result checker: every accepted result against the oldest prediction ----
	always @(posedge clk) begin
		pins_t want;
		pins_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{scl_out, sda_out, sda_drive, busy_res, write_taken, read_valid,
				read_byte, done_res, fail};
			if (done_res === 1'b1) begin
				done_seen++;
				last_fail = fail;
			end
			if (pins_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result word with none expected, got %h", $time, got);
			end else begin
				want = pins_due.pop_front();
				if (want.scl !== got.scl) flag_field("scl_out", want.scl, got.scl);
				if (want.sda !== got.sda) flag_field("sda_out", want.sda, got.sda);
				if (want.drv !== got.drv) flag_field("sda_drive", want.drv, got.drv);
				if (want.busy !== got.busy) flag_field("busy_res", want.busy, got.busy);
				if (want.wtaken !== got.wtaken)
					flag_field("write_taken", want.wtaken, got.wtaken);
				if (want.rvalid !== got.rvalid)
					flag_field("read_valid", want.rvalid, got.rvalid);
				if (want.rbyte !== got.rbyte) flag_field("read_byte", want.rbyte, got.rbyte);
				if (want.done !== got.done) flag_field("done_res", want.done, got.done);
				if (want.fail !== got.fail) flag_field("fail", want.fail, got.fail);
			end
		end
	end

	// ---- receiver: random stalls, plus a long hold-off when asked ----
	initial begin
		int stall_left;
		int hold;
		out_ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				// sender keeps offering words, so the block fills and stalls
				out_ready = 1'b0;
				hold = rx_hold;
				rx_hold = 0;
				repeat (hold - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
			end
		end
	end

	// ---- watchdog ----
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ---- main sequence ----
	initial begin
		txn_row_t row;
		int       dones_before;
		int       n_noise;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEV_ADDR;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		start_req = 1'b0;
		func = 1'b0;
		reg_addr = 8'd0;
		length = 8'd0;
		wr_data = 8'd0;
		sda_in = 1'b1;
		errors = 0;
		done_seen = 0;
		last_fail = 1'b0;
		rx_hold = 0;
		no_idle = 1'b0;
		clear_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_ROWS; i++) begin
			row = ROWS[i];
			apply_cfg(row.addr, row.limit, row.tpu);
			no_idle = (row.tpu > 8'd8);  // very slow bit timing: no gaps on top
			dones_before = done_seen;
			run_txn(row.fn, row.reg_a, row.len, row.plan, int'(row.nack_at));
			wait_quiet();
			if (row.chk != CHK_NONE &&
					(done_seen != dones_before + 1 || last_fail !== (row.chk == CHK_FAIL))) begin
				errors++;
				$display("%0t: row %0d expected one done with fail %0b, saw %0d, fail %b",
					$time, i, row.chk == CHK_FAIL, done_seen - dones_before, last_fail);
			end
		end
		no_idle = 1'b0;

		// random transaction on random settings, a zero divider included
		apply_cfg(7'($urandom), 8'($urandom_range(1, 3)), 8'($urandom_range(0, 1)));
		// a few idle words with no request first
		n_noise = $urandom_range(0, 3);
		repeat (n_noise)
			send_word(1'b0, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				1'($urandom));
		no_idle = ($urandom_range(0, 3) == 0);
		rx_hold = 60;
		run_txn(1'($urandom), 8'($urandom), 8'd0, pick_plan(), 0);
		wait_quiet();  // sender pauses until the last result is back

		in_valid = 1'b0;
		while (pins_due.size() != 0) @(negedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0 && pins_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
